// File: src/fprm_pkg.sv
// Shared constants, codes and types for the frame pacing rate meter.
package fprm_pkg;

  localparam int unsigned WINDOW_LENGTH_DEF = 120;

  localparam int unsigned CMD_W     = 1;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned WAIT_W    = 17;
  localparam int unsigned RATE_W    = 21;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Shared divider: dividend covers 10000*255 and 1000*256, divisor a full time span.
  localparam int unsigned DIVIDEND_W = 22;
  localparam int unsigned DIVISOR_W  = 32;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  localparam int unsigned MS_PER_S     = 1000;
  localparam int unsigned TENTHS_SCALE = 10000;

  localparam logic [CMD_W-1:0] CMD_QUERY    = 1'b0;
  localparam logic [CMD_W-1:0] CMD_REGISTER = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FPS      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INTERVAL = 1'b1;

  localparam logic [CFG_W-1:0] TARGET_FPS_RST      = 8'd60;
  localparam logic [CFG_W-1:0] UPDATE_INTERVAL_RST = 8'd60;

  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: src/fprm_if.sv
// Valid/ready channel interfaces for the query/register items and the results.
interface fprm_in_if;
  logic                        valid;
  logic                        ready;
  logic [fprm_pkg::CMD_W-1:0]  cmd;
  logic [fprm_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, cmd, now_ms, input ready);
  modport sink   (input valid, cmd, now_ms, output ready);
endinterface

interface fprm_out_if;
  logic                        valid;
  logic                        ready;
  logic [fprm_pkg::WAIT_W-1:0] wait_ms;
  logic [fprm_pkg::RATE_W-1:0] fps_tenths;
  logic                        fps_valid;

  modport source (output valid, wait_ms, fps_tenths, fps_valid, input ready);
  modport sink   (input valid, wait_ms, fps_tenths, fps_valid, output ready);
endinterface

// File: src/fprm_ring.sv
// Timestamp ring memory: one write port, one registered read port.
module fprm_ring #(
  parameter int unsigned Depth = fprm_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth)-1:0]         waddr_i,
  input  logic [fprm_pkg::TIME_W-1:0]      wdata_i,
  input  logic [$clog2(Depth)-1:0]         raddr_i,
  output logic [fprm_pkg::TIME_W-1:0]      rdata_o
);

  logic [fprm_pkg::TIME_W-1:0] mem [Depth];
  logic [fprm_pkg::TIME_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/fprm_div.sv
// Shared restoring divider, one quotient bit per cycle.
module fprm_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [fprm_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  logic [fprm_pkg::DIVISOR_W-1:0]    divisor_i,
  output logic [fprm_pkg::DIVIDEND_W-1:0]   quotient_o,
  output fprm_pkg::div_stat_t               stat_o
);

  localparam int unsigned DW = fprm_pkg::DIVIDEND_W;
  localparam int unsigned RW = fprm_pkg::DIVISOR_W;

  logic [RW-1:0]                       rem_q, rem_d;
  logic [DW-1:0]                       quo_q, quo_d;
  logic [RW-1:0]                       dsr_q;
  logic [fprm_pkg::DIV_CNT_W-1:0]      cnt_q;
  logic                                busy_q, done_q;
  logic [RW:0]                         trial, diff;

  // Quotient bits shift in from the bottom while dividend bits leave the top.
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    diff  = trial - {1'b0, dsr_q};
    if (!diff[RW]) begin
      rem_d = diff[RW-1:0];
      quo_d = {quo_q[DW-2:0], 1'b1};
    end else begin
      rem_d = trial[RW-1:0];
      quo_d = {quo_q[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= fprm_pkg::DIV_CNT_W'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == fprm_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: src/frame_pacing_rate_meter.sv
// Top level: sequencer, pacing state and result register of the rate meter.
//
// Usage: items enter on in_i (cmd, now_ms). A query item (cmd 0) returns the
// time to wait, floor(1000*count/target_fps) minus the time since the oldest
// stored frame, clamped at zero. A register item (cmd 1) stores now_ms in the
// timestamp ring and, every update_interval frames with a full ring, refreshes
// the measured rate 10000*(count-1)/span in tenths of fps. Every item yields
// exactly one result on out_o carrying wait_ms, fps_tenths and fps_valid.
// Steps: an item that divides passes ST_READ, which forms the elapsed time or
// span and starts the divider, ST_DIV, which waits for the divider and takes
// the quotient, and ST_FIN, which loads the output register. Items with no
// division go from ST_READ straight to ST_FIN. The divider yields one quotient
// bit per cycle, and in_i.ready stays low from acceptance until the result is
// handed to the output register. The output register lets the next item be
// accepted while a result waits; if the receiver stalls and a second result is
// ready, the sequencer holds it. Reset clears the fill count, oldest slot,
// frame counter and measured rate, and loads target_fps and update_interval
// with 60. The ring memory is not cleared: only filled slots are ever used.
// Configuration is written with cfg_we_i/cfg_idx_i/cfg_data_i.
module frame_pacing_rate_meter #(
  parameter int unsigned WINDOW_LENGTH = fprm_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fprm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fprm_pkg::CFG_W-1:0]          cfg_data_i,
  fprm_in_if.sink                             in_i,
  fprm_out_if.source                          out_o
);

  localparam int unsigned SLOT_W = $clog2(WINDOW_LENGTH);
  localparam int unsigned FILL_W = $clog2(WINDOW_LENGTH + 1);
  localparam int unsigned SUM_W  = SLOT_W + 1;
  localparam int unsigned DW     = fprm_pkg::DIVIDEND_W;
  localparam int unsigned TW     = fprm_pkg::TIME_W;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LENGTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LENGTH - 1);
  localparam logic [SUM_W-1:0]  SUM_WRAP  = SUM_W'(WINDOW_LENGTH);
  // Numerator of the rate: (count-1) frame intervals in tenths of fps.
  localparam logic [DW-1:0] RATE_NUM = DW'(fprm_pkg::TENTHS_SCALE * (WINDOW_LENGTH - 1));

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                          state_q;
  logic [FILL_W-1:0]               fill_q;
  logic [SLOT_W-1:0]               oldest_q;
  logic [7:0]                      frame_cnt_q;
  logic [fprm_pkg::RATE_W-1:0]     rate_q;
  logic [fprm_pkg::CFG_W-1:0]      fps_q, interval_q;
  logic [fprm_pkg::CMD_W-1:0]      cmd_q;
  logic [TW-1:0]                   now_q;
  logic                            upd_q;
  logic [TW-1:0]                   elapsed_q;
  logic [fprm_pkg::WAIT_W-1:0]     wait_q;
  logic                            out_valid_q;
  logic [fprm_pkg::WAIT_W-1:0]     out_wait_q;
  logic [fprm_pkg::RATE_W-1:0]     out_rate_q;

  logic                            in_acc;
  logic                            full;
  logic [SUM_W-1:0]                slot_sum, slot_wrap;
  logic [SLOT_W-1:0]               waddr, raddr, oldest_inc;
  logic [7:0]                      frame_inc;
  logic                            ring_we;
  logic [TW-1:0]                   ring_rdata;
  logic [TW-1:0]                   delta;
  logic [fprm_pkg::CFG_W-1:0]      fps_eff;

  logic                            div_start;
  logic [DW-1:0]                   div_dividend;
  logic [fprm_pkg::DIVISOR_W-1:0]  div_divisor;
  logic [DW-1:0]                   div_quo;
  fprm_pkg::div_stat_t             div_st;

  logic [DW-1:0]                   wait_diff;
  logic [fprm_pkg::WAIT_W-1:0]     wait_new;
  logic [fprm_pkg::RATE_W-1:0]     rate_new;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // Ring addressing: the next free slot while filling, else overwrite the oldest.
  assign full       = (fill_q == FILL_FULL);
  assign slot_sum   = {1'b0, oldest_q} + SUM_W'(fill_q);
  assign slot_wrap  = (slot_sum >= SUM_WRAP) ? (slot_sum - SUM_WRAP) : slot_sum;
  assign oldest_inc = (oldest_q == SLOT_LAST) ? '0 : (oldest_q + 1'b1);
  assign waddr      = full ? oldest_q : slot_wrap[SLOT_W-1:0];
  assign frame_inc  = frame_cnt_q + 8'd1;
  assign ring_we    = in_acc && (in_i.cmd == fprm_pkg::CMD_REGISTER);

  // Read the oldest slot as it stands after this item's push. The newest
  // stamp of a full ring is the one being pushed, so the span needs only one read.
  assign raddr = (ring_we && full) ? oldest_inc : oldest_q;

  fprm_ring #(
    .Depth (WINDOW_LENGTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (waddr),
    .wdata_i (in_i.now_ms),
    .raddr_i (raddr),
    .rdata_o (ring_rdata)
  );

  // Elapsed time (query) or span (register), both modulo 2^32.
  assign delta   = now_q - ring_rdata;
  assign fps_eff = (fps_q == '0) ? fprm_pkg::CFG_W'(1) : fps_q;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = RATE_NUM;
    div_divisor  = delta;
    if (state_q == ST_READ) begin
      if (cmd_q == fprm_pkg::CMD_QUERY) begin
        div_start    = (fill_q != '0);
        div_dividend = DW'(fill_q) * DW'(fprm_pkg::MS_PER_S);
        div_divisor  = fprm_pkg::DIVISOR_W'(fps_eff);
      end else begin
        div_start = upd_q && full && (delta != '0);
      end
    end
  end

  fprm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .stat_o     (div_st)
  );

  // Wait = budget - elapsed, zero once elapsed reaches the budget, saturated.
  assign wait_diff = div_quo - elapsed_q[DW-1:0];
  always_comb begin
    if (elapsed_q >= TW'(div_quo)) begin
      wait_new = '0;
    end else if (wait_diff[DW-1:fprm_pkg::WAIT_W] != '0) begin
      wait_new = fprm_pkg::WAIT_MAX;
    end else begin
      wait_new = wait_diff[fprm_pkg::WAIT_W-1:0];
    end
  end

  assign rate_new = (div_quo[DW-1:fprm_pkg::RATE_W] != '0) ? fprm_pkg::RATE_MAX
                                                           : div_quo[fprm_pkg::RATE_W-1:0];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fps_q      <= fprm_pkg::TARGET_FPS_RST;
      interval_q <= fprm_pkg::UPDATE_INTERVAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fprm_pkg::CFG_TARGET_FPS:      fps_q      <= cfg_data_i;
        fprm_pkg::CFG_UPDATE_INTERVAL: interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Item payload captured at acceptance.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= in_i.cmd;
      now_q <= in_i.now_ms;
    end
    if (state_q == ST_READ) begin
      elapsed_q <= delta;
    end
    if (out_valid_q == 1'b0 || out_o.ready) begin
      if (state_q == ST_FIN) begin
        out_wait_q <= wait_q;
        out_rate_q <= rate_q;
      end
    end
  end

  // Sequencer, ring bookkeeping and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      oldest_q    <= '0;
      frame_cnt_q <= '0;
      rate_q      <= '0;
      upd_q       <= 1'b0;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            upd_q   <= 1'b0;
            state_q <= ST_READ;
            if (in_i.cmd == fprm_pkg::CMD_REGISTER) begin
              if (full) begin
                oldest_q <= oldest_inc;
              end else begin
                fill_q <= fill_q + 1'b1;
              end
              // Interval reached (or lowered below the count): refresh and restart.
              if (frame_inc >= interval_q) begin
                upd_q       <= 1'b1;
                frame_cnt_q <= '0;
              end else begin
                frame_cnt_q <= frame_inc;
              end
            end
          end
        end
        ST_READ: begin
          wait_q  <= '0;
          state_q <= div_start ? ST_DIV : ST_FIN;
        end
        ST_DIV: begin
          if (div_st.done) begin
            if (cmd_q == fprm_pkg::CMD_QUERY) begin
              wait_q <= wait_new;
            end else begin
              rate_q <= rate_new;
            end
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.wait_ms    = out_wait_q;
  assign out_o.fps_tenths = out_rate_q;
  assign out_o.fps_valid  = (out_rate_q != '0);

  // The ring never holds more stamps than it has slots.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("ring fill count beyond window");

  // Once accepted, no further item enters until this one's result is handed off.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("item accepted while another is in flight");

  // Divider results only arrive while the sequencer waits for them.
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");

  // The divider is started only when idle.
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_st.busy)
    else $error("divider restarted while busy");

  // Register items never report a wait.
  a_reg_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && cmd_q == fprm_pkg::CMD_REGISTER) |-> (wait_q == '0))
    else $error("register item produced a nonzero wait");

endmodule
